[hdl/tfn_pkg.sv]
// tfn_pkg: shared constants and control types for the triangle face normal block.
// Used by tfn_front, tfn_cell and triangle_face_normal. No dependencies.
package tfn_pkg;

  // Default field widths
  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned NormalFracBits = 14;

  // Control carried alongside each item through the pipe
  typedef struct packed {
    logic valid;
    logic degen;
  } tfn_ctl_t;

endpackage

[hdl/tfn_front.sv]
// tfn_front: edge vectors, cross product, squared components and squared length.
// Five register stages. Depends on tfn_pkg.
module tfn_front #(
  parameter int unsigned CW = 16,
  parameter int unsigned SW = 2 * (2 * (CW + 1) + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [CW-1:0]        a_i [3],
  input  logic [CW-1:0]        b_i [3],
  input  logic [CW-1:0]        c_i [3],
  output tfn_pkg::tfn_ctl_t    ctl_o,
  output logic [SW-1:0]        s_o,
  output logic [SW-1:0]        sq_o [3],
  output logic [2:0]           neg_o
);
  import tfn_pkg::*;

  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned VW = PW + 1;

  logic              [4:0]    vld_q;
  logic signed [EW-1:0] u_q [3];
  logic signed [EW-1:0] w_q [3];
  logic signed [PW-1:0] p_q [6];
  logic signed [VW-1:0] v_q [3];
  logic        [SW-1:0] sq_q [3];
  logic        [SW-1:0] msq_q [3];
  logic        [SW-1:0] s_q;
  logic        [2:0]    neg4_q, neg5_q;
  logic                 zero4_q, zero5_q;
  logic        [VW-2:0] mag [3];

  // Magnitude of each cross product component
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = v_q[k][VW-1] ? (VW-1)'(-v_q[k]) : v_q[k][VW-2:0];
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= $signed({b_i[k][CW-1], b_i[k]}) - $signed({a_i[k][CW-1], a_i[k]});
        w_q[k] <= $signed({c_i[k][CW-1], c_i[k]}) - $signed({a_i[k][CW-1], a_i[k]});
      end
      // V = W x U
      p_q[0] <= PW'(w_q[1]) * PW'(u_q[2]);
      p_q[1] <= PW'(w_q[2]) * PW'(u_q[1]);
      p_q[2] <= PW'(w_q[2]) * PW'(u_q[0]);
      p_q[3] <= PW'(w_q[0]) * PW'(u_q[2]);
      p_q[4] <= PW'(w_q[0]) * PW'(u_q[1]);
      p_q[5] <= PW'(w_q[1]) * PW'(u_q[0]);
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= VW'(p_q[2*k]) - VW'(p_q[2*k+1]);
      end
      for (int k = 0; k < 3; k++) begin
        sq_q[k]   <= SW'(mag[k]) * SW'(mag[k]);
        neg4_q[k] <= v_q[k][VW-1];
      end
      zero4_q <= (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
      s_q     <= sq_q[0] + sq_q[1] + sq_q[2];
      msq_q   <= sq_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  assign ctl_o.valid = vld_q[4];
  assign ctl_o.degen = zero5_q;
  assign s_o         = s_q;
  assign sq_o        = msq_q;
  assign neg_o       = neg5_q;

endmodule

[hdl/tfn_cell.sv]
// tfn_cell: one result bit of the rounded normalisation, for all three components.
// Restoring square-root style step on wide residuals. Depends on tfn_pkg.
module tfn_cell #(
  parameter int unsigned SW = 70,
  parameter int unsigned RW = 103,
  parameter int unsigned F  = 14,
  parameter int unsigned B  = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tfn_pkg::tfn_ctl_t    ctl_i,
  input  logic [SW-1:0]        s_i,
  input  logic signed [RW-1:0] r_i [3],
  input  logic signed [RW-1:0] p_i [3],
  input  logic [F:0]           q_i [3],
  input  logic [2:0]           neg_i,
  output tfn_pkg::tfn_ctl_t    ctl_o,
  output logic [SW-1:0]        s_o,
  output logic signed [RW-1:0] r_o [3],
  output logic signed [RW-1:0] p_o [3],
  output logic [F:0]           q_o [3],
  output logic [2:0]           neg_o
);
  import tfn_pkg::*;

  tfn_ctl_t             ctl_q;
  logic [SW-1:0]        s_q;
  logic signed [RW-1:0] r_q [3], p_q [3];
  logic signed [RW-1:0] r_d [3], p_d [3];
  logic [F:0]           q_q [3], q_d [3];
  logic [2:0]           neg_q;
  logic signed [RW-1:0] s_ext, t, diff;

  // Trial (2q+2^(B+1)-1)^2 * S against the residual
  always_comb begin
    s_ext = $signed(RW'(s_i));
    t     = '0;
    diff  = '0;
    for (int k = 0; k < 3; k++) begin
      t    = (p_i[k] <<< (B + 2)) + (s_ext <<< (2 * B + 2));
      diff = r_i[k] - t;
      if (!diff[RW-1]) begin
        r_d[k] = diff;
        p_d[k] = p_i[k] + (s_ext <<< (B + 1));
        q_d[k] = q_i[k] | ((F+1)'(1) << B);
      end else begin
        r_d[k] = r_i[k];
        p_d[k] = p_i[k];
        q_d[k] = q_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= s_i;
      r_q   <= r_d;
      p_q   <= p_d;
      q_q   <= q_d;
      neg_q <= neg_i;
    end
  end

  assign ctl_o = ctl_q;
  assign s_o   = s_q;
  assign r_o   = r_q;
  assign p_o   = p_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;

endmodule

[hdl/triangle_face_normal.sv]
// triangle_face_normal: unit face normal of a triangle, rounded to nearest.
// Instantiates tfn_front and a row of tfn_cell; depends on tfn_pkg.
//
//   channel  direction  handshake          payload
//   input    in         valid_i / stall_o  ax_i .. cz_i
//   output   out        valid_o / stall_i  normal_x_o .. normal_z_o, degenerate_o
//
// One item per cycle while not stalled; the pipe is five front stages,
// one cell per result bit and one output register.
// The whole pipe advances together; it holds when a result waits under stall_i.
// Reset clears only the valid bits and the cells' control words; no clearing pass.
module triangle_face_normal #(
  parameter int unsigned COORD_WIDTH      = tfn_pkg::CoordWidth,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NormalFracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [COORD_WIDTH-1:0]      ax_i,
  input  logic [COORD_WIDTH-1:0]      ay_i,
  input  logic [COORD_WIDTH-1:0]      az_i,
  input  logic [COORD_WIDTH-1:0]      bx_i,
  input  logic [COORD_WIDTH-1:0]      by_i,
  input  logic [COORD_WIDTH-1:0]      bz_i,
  input  logic [COORD_WIDTH-1:0]      cx_i,
  input  logic [COORD_WIDTH-1:0]      cy_i,
  input  logic [COORD_WIDTH-1:0]      cz_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                        degenerate_o
);
  import tfn_pkg::*;

  localparam int unsigned F  = NORMAL_FRAC_BITS;
  localparam int unsigned OW = F + 2;
  localparam int unsigned SW = 2 * (2 * (COORD_WIDTH + 1) + 1);
  localparam int unsigned RW = SW + 2 * F + 5;

  logic                 en;
  logic [COORD_WIDTH-1:0] a [3], b [3], c [3];
  tfn_ctl_t             ctl_w [F+2];
  logic [SW-1:0]        s_w   [F+2];
  logic signed [RW-1:0] r_w   [F+2][3];
  logic signed [RW-1:0] p_w   [F+2][3];
  logic [F:0]           q_w   [F+2][3];
  logic [2:0]           neg_w [F+2];
  logic [SW-1:0]        msq   [3];
  logic [OW-1:0]        n_d [3];
  logic [OW-1:0]        n_q [3];
  logic                 vld_q, degen_q;

  // Pipe moves unless a finished item is held at the output
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  assign a = '{ax_i, ay_i, az_i};
  assign b = '{bx_i, by_i, bz_i};
  assign c = '{cx_i, cy_i, cz_i};

  tfn_front #(.CW(COORD_WIDTH), .SW(SW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .a_i(a), .b_i(b), .c_i(c),
    .ctl_o(ctl_w[0]), .s_o(s_w[0]), .sq_o(msq), .neg_o(neg_w[0])
  );

  // Initial residual R = 4^(F+1) m^2 - S, P = -S, q = 0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_w[0][k] = $signed((RW'(msq[k]) << (2 * F + 2)) - RW'(s_w[0]));
      p_w[0][k] = $signed(RW'(0) - RW'(s_w[0]));
      q_w[0][k] = '0;
    end
  end

  // One cell per result bit, most significant first
  for (genvar i = 0; i <= F; i++) begin : g_cell
    tfn_cell #(.SW(SW), .RW(RW), .F(F), .B(F - i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .ctl_i(ctl_w[i]), .s_i(s_w[i]), .r_i(r_w[i]), .p_i(p_w[i]),
      .q_i(q_w[i]), .neg_i(neg_w[i]),
      .ctl_o(ctl_w[i+1]), .s_o(s_w[i+1]), .r_o(r_w[i+1]), .p_o(p_w[i+1]),
      .q_o(q_w[i+1]), .neg_o(neg_w[i+1])
    );
  end

  // Sign and degenerate override
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (ctl_w[F+1].degen) begin
        n_d[k] = '0;
      end else if (neg_w[F+1][k]) begin
        n_d[k] = OW'(0) - OW'(q_w[F+1][k]);
      end else begin
        n_d[k] = OW'(q_w[F+1][k]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= ctl_w[F+1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q     <= n_d;
      degen_q <= ctl_w[F+1].degen;
    end
  end

  assign valid_o      = vld_q;
  assign normal_x_o   = n_q[0];
  assign normal_y_o   = n_q[1];
  assign normal_z_o   = n_q[2];
  assign degenerate_o = degen_q;

  // A degenerate item carries a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> n_q[0] == '0 && n_q[1] == '0 && n_q[2] == '0)
    else $error("degenerate item with non-zero normal");

  // A proper unit normal never rounds to all zeros
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !degenerate_o |-> n_q[0] != '0 || n_q[1] != '0 || n_q[2] != '0)
    else $error("unit normal rounded to zero");

  // Held output keeps its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(n_q[0]) && $stable(degen_q))
    else $error("held item changed");

endmodule
